### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame decoder checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CFSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define CFSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/cfsd_pkg.sv
// ----------------------------------------------------------------------------
// CAN frame signal decoder package
// Types, constants, the entry table and the microprogram of the decoder.
// ----------------------------------------------------------------------------
package cfsd_pkg;

    localparam int unsigned IdWidth    = 29;
    localparam int unsigned DataWidth  = 64;
    localparam int unsigned BaseWidth  = 11;
    localparam int unsigned IndexWidth = 7;
    localparam int unsigned ValueWidth = 32;
    localparam int unsigned OffWidth   = 6;
    localparam logic [BaseWidth-1:0] BaseIdReset = 11'd160;

    typedef enum logic [4:0] {
        OP_W16_0,
        OP_W16_2,
        OP_W16_4,
        OP_W16_6,
        OP_B0,
        OP_B1,
        OP_B2,
        OP_B3,
        OP_B4,
        OP_B5,
        OP_B6,
        OP_B7,
        OP_A0,
        OP_A1,
        OP_A2,
        OP_B4_BIT0,
        OP_B4_TOP3,
        OP_B6_BIT0,
        OP_B6_BIT7,
        OP_B7_BIT0,
        OP_B7_BIT1,
        OP_B7_BIT2,
        OP_W32_4,
        OP_BE_0,
        OP_BE_4
    } t_op;

    typedef struct packed {
        t_op  op;
        logic eop;
    } t_uword;

    typedef struct packed {
        logic                  hit;
        logic [IndexWidth-1:0] addr;
    } t_entry;

    typedef struct packed {
        logic                  step;
        t_op                   op;
        logic [IndexWidth-1:0] index;
        logic                  last;
    } t_ctl;

    localparam logic [OffWidth-1:0] OffQuad0   = 6'h00;
    localparam logic [OffWidth-1:0] OffQuad1   = 6'h01;
    localparam logic [OffWidth-1:0] OffQuad2   = 6'h02;
    localparam logic [OffWidth-1:0] OffAnalog  = 6'h03;
    localparam logic [OffWidth-1:0] OffBytes   = 6'h04;
    localparam logic [OffWidth-1:0] OffQuad5   = 6'h05;
    localparam logic [OffWidth-1:0] OffQuad6   = 6'h06;
    localparam logic [OffWidth-1:0] OffQuad7   = 6'h07;
    localparam logic [OffWidth-1:0] OffQuad8   = 6'h08;
    localparam logic [OffWidth-1:0] OffQuad9   = 6'h09;
    localparam logic [OffWidth-1:0] OffStatus  = 6'h0A;
    localparam logic [OffWidth-1:0] OffQuadB   = 6'h0B;
    localparam logic [OffWidth-1:0] OffTorque  = 6'h0C;
    localparam logic [OffWidth-1:0] OffQuadD   = 6'h0D;
    localparam logic [OffWidth-1:0] OffQuadE   = 6'h0E;
    localparam logic [OffWidth-1:0] OffDiag    = 6'h0F;
    localparam logic [OffWidth-1:0] OffQuad10  = 6'h10;

    // Maps an identifier offset to the first step of its message. The
    // parameter response and all unused offsets have no program.
    function automatic t_entry entry_of(input logic [OffWidth-1:0] off);
        t_entry e;
        e.hit = 1'b1;
        unique case (off)
            OffQuad0:  e.addr = 7'd0;
            OffQuad1:  e.addr = 7'd4;
            OffQuad2:  e.addr = 7'd8;
            OffAnalog: e.addr = 7'd12;
            OffBytes:  e.addr = 7'd17;
            OffQuad5:  e.addr = 7'd25;
            OffQuad6:  e.addr = 7'd29;
            OffQuad7:  e.addr = 7'd33;
            OffQuad8:  e.addr = 7'd37;
            OffQuad9:  e.addr = 7'd41;
            OffStatus: e.addr = 7'd45;
            OffQuadB:  e.addr = 7'd56;
            OffTorque: e.addr = 7'd60;
            OffQuadD:  e.addr = 7'd63;
            OffQuadE:  e.addr = 7'd67;
            OffDiag:   e.addr = 7'd71;
            OffQuad10: e.addr = 7'd73;
            default: begin
                e.hit  = 1'b0;
                e.addr = '0;
            end
        endcase
        return e;
    endfunction

    // Microprogram: the step address is also the signal index.
    function automatic t_uword rom_word(input logic [IndexWidth-1:0] addr);
        t_uword w;
        unique case (addr)
            7'd0, 7'd4, 7'd8, 7'd12, 7'd25, 7'd29, 7'd33, 7'd37, 7'd41,
            7'd45, 7'd56, 7'd60, 7'd63, 7'd67, 7'd73:             w.op = OP_W16_0;
            7'd1, 7'd5, 7'd9, 7'd13, 7'd26, 7'd30, 7'd34, 7'd38, 7'd42,
            7'd57, 7'd61, 7'd64, 7'd68, 7'd74:                    w.op = OP_W16_2;
            7'd2, 7'd6, 7'd10, 7'd27, 7'd31, 7'd35, 7'd39, 7'd43,
            7'd58, 7'd65, 7'd69, 7'd75:                           w.op = OP_W16_4;
            7'd3, 7'd7, 7'd11, 7'd28, 7'd32, 7'd36, 7'd40, 7'd44,
            7'd59, 7'd66, 7'd70, 7'd76:                           w.op = OP_W16_6;
            7'd14: w.op = OP_A0;
            7'd15: w.op = OP_A1;
            7'd16: w.op = OP_A2;
            7'd17: w.op = OP_B0;
            7'd18: w.op = OP_B1;
            7'd19, 7'd46: w.op = OP_B2;
            7'd20, 7'd47: w.op = OP_B3;
            7'd21: w.op = OP_B4;
            7'd22, 7'd50: w.op = OP_B5;
            7'd23: w.op = OP_B6;
            7'd24: w.op = OP_B7;
            7'd48: w.op = OP_B4_BIT0;
            7'd49: w.op = OP_B4_TOP3;
            7'd51: w.op = OP_B6_BIT0;
            7'd52: w.op = OP_B6_BIT7;
            7'd53: w.op = OP_B7_BIT0;
            7'd54: w.op = OP_B7_BIT1;
            7'd55: w.op = OP_B7_BIT2;
            7'd62: w.op = OP_W32_4;
            7'd71: w.op = OP_BE_0;
            7'd72: w.op = OP_BE_4;
            default: w.op = OP_W16_0;
        endcase
        unique case (addr)
            7'd3, 7'd7, 7'd11, 7'd16, 7'd24, 7'd28, 7'd32, 7'd36, 7'd40,
            7'd44, 7'd55, 7'd59, 7'd62, 7'd66, 7'd70, 7'd72, 7'd76: w.eop = 1'b1;
            7'd0, 7'd1, 7'd2, 7'd4, 7'd5, 7'd6, 7'd8, 7'd9, 7'd10, 7'd12,
            7'd13, 7'd14, 7'd15, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22,
            7'd23, 7'd25, 7'd26, 7'd27, 7'd29, 7'd30, 7'd31, 7'd33, 7'd34,
            7'd35, 7'd37, 7'd38, 7'd39, 7'd41, 7'd42, 7'd43, 7'd45, 7'd46,
            7'd47, 7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd56,
            7'd57, 7'd58, 7'd60, 7'd61, 7'd63, 7'd64, 7'd65, 7'd67, 7'd68,
            7'd69, 7'd71, 7'd73, 7'd74, 7'd75: w.eop = 1'b0;
            default: w.eop = 1'b1;
        endcase
        return w;
    endfunction

endpackage

### src/can_frame_signal_decoder_top.sv
// ----------------------------------------------------------------------------
// CAN frame signal decoder
// A frame is taken whole from the input stream. When its identifier equals
// base_id plus one of the broadcast offsets, a microprogram sequencer issues
// one decoded signal per cycle into the output register while the output side
// accepts. A message with N signals (2 to 11) keeps the input stalled after
// the frame is taken until the sequencer has issued its last signal. Frames
// that do not match, and the parameter response, produce no request and leave
// the input ready in the next cycle. The single step issue of the sequencer
// sets the rate of matching frames.
// ----------------------------------------------------------------------------
module can_frame_signal_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [10:0] i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // can_id [28:0], frame_data [92:29], zero [95:93]
    input  logic [95:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // signal_index [6:0], signal_value [38:7], zero [39]
    output logic [39:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);
    import cfsd_pkg::*;

    logic [BaseWidth-1:0]  r_base_id;
    logic                  w_accept;
    logic [IdWidth-1:0]    w_can_id;
    logic [IdWidth:0]      w_diff;
    t_entry                w_entry;
    logic                  w_start;
    logic                  w_busy;
    logic                  w_out_free;
    t_ctl                  w_ctl;
    logic [IndexWidth-1:0] w_index;
    logic [ValueWidth-1:0] w_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_id <= BaseIdReset;
        end else if (i_cfg_wr_en) begin
            r_base_id <= i_cfg_wr_data;
        end
    end

    assign w_can_id = i_s_axis_tdata[IdWidth-1:0];
    assign w_diff   = {1'b0, w_can_id} - {{(IdWidth+1-BaseWidth){1'b0}}, r_base_id};
    assign w_entry  = entry_of(w_diff[OffWidth-1:0]);

    assign o_s_axis_tready = !w_busy;
    assign w_accept        = i_s_axis_tvalid && !w_busy;
    assign w_start         = w_accept && (w_diff[IdWidth:OffWidth] == '0) && w_entry.hit;

    cfsd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_entry    (w_entry.addr),
        .i_out_free (w_out_free),
        .o_busy     (w_busy),
        .o_ctl      (w_ctl)
    );

    cfsd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_data     (i_s_axis_tdata[IdWidth+DataWidth-1:IdWidth]),
        .i_ctl      (w_ctl),
        .i_ready    (i_m_axis_tready),
        .o_out_free (w_out_free),
        .o_valid    (o_m_axis_tvalid),
        .o_index    (w_index),
        .o_value    (w_value),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, w_value, w_index};

endmodule

### src/cfsd_seq.sv
// ----------------------------------------------------------------------------
// Microprogram sequencer
// Step counter over the microprogram; issues one control word per step.
// ----------------------------------------------------------------------------
module cfsd_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [cfsd_pkg::IndexWidth-1:0] i_entry,
    input  logic                           i_out_free,
    output logic                           o_busy,
    output cfsd_pkg::t_ctl                 o_ctl
);
    import cfsd_pkg::*;

    logic                  r_busy, n_busy;
    logic [IndexWidth-1:0] r_pc, n_pc;
    t_uword                w_word;
    logic                  w_step;

    assign w_word = rom_word(r_pc);
    assign w_step = r_busy && i_out_free;

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        priority if (i_start) begin
            n_busy = 1'b1;
            n_pc   = i_entry;
        end else if (w_step) begin
            if (w_word.eop) begin
                n_busy = 1'b0;
            end else begin
                n_pc = r_pc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc <= n_pc;
    end

    assign o_busy      = r_busy;
    assign o_ctl.step  = w_step;
    assign o_ctl.op    = w_word.op;
    assign o_ctl.index = r_pc;
    assign o_ctl.last  = w_word.eop;

endmodule

### src/cfsd_dp.sv
// ----------------------------------------------------------------------------
// Decoder datapath
// Frame payload register, field extraction and the output register.
// ----------------------------------------------------------------------------
module cfsd_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic [cfsd_pkg::DataWidth-1:0]  i_data,
    input  cfsd_pkg::t_ctl                  i_ctl,
    input  logic                            i_ready,
    output logic                            o_out_free,
    output logic                            o_valid,
    output logic [cfsd_pkg::IndexWidth-1:0] o_index,
    output logic [cfsd_pkg::ValueWidth-1:0] o_value,
    output logic                            o_last
);
    import cfsd_pkg::*;

    logic [DataWidth-1:0]  r_data;
    logic                  r_valid, n_valid;
    logic [IndexWidth-1:0] r_index;
    logic [ValueWidth-1:0] r_value;
    logic                  r_last;
    logic [ValueWidth-1:0] w_field;

    always_comb begin
        unique case (i_ctl.op)
            OP_W16_0:   w_field = {16'd0, r_data[15:0]};
            OP_W16_2:   w_field = {16'd0, r_data[31:16]};
            OP_W16_4:   w_field = {16'd0, r_data[47:32]};
            OP_W16_6:   w_field = {16'd0, r_data[63:48]};
            OP_B0:      w_field = {24'd0, r_data[7:0]};
            OP_B1:      w_field = {24'd0, r_data[15:8]};
            OP_B2:      w_field = {24'd0, r_data[23:16]};
            OP_B3:      w_field = {24'd0, r_data[31:24]};
            OP_B4:      w_field = {24'd0, r_data[39:32]};
            OP_B5:      w_field = {24'd0, r_data[47:40]};
            OP_B6:      w_field = {24'd0, r_data[55:48]};
            OP_B7:      w_field = {24'd0, r_data[63:56]};
            OP_A0:      w_field = {22'd0, r_data[41:32]};
            OP_A1:      w_field = {22'd0, r_data[51:42]};
            OP_A2:      w_field = {22'd0, r_data[61:52]};
            OP_B4_BIT0: w_field = {31'd0, r_data[32]};
            OP_B4_TOP3: w_field = {29'd0, r_data[39:37]};
            OP_B6_BIT0: w_field = {31'd0, r_data[48]};
            OP_B6_BIT7: w_field = {31'd0, r_data[55]};
            OP_B7_BIT0: w_field = {31'd0, r_data[56]};
            OP_B7_BIT1: w_field = {31'd0, r_data[57]};
            OP_B7_BIT2: w_field = {31'd0, r_data[58]};
            OP_W32_4:   w_field = r_data[63:32];
            OP_BE_0:    w_field = {r_data[7:0], r_data[15:8], r_data[23:16], r_data[31:24]};
            OP_BE_4:    w_field = {r_data[39:32], r_data[47:40], r_data[55:48],
                                   r_data[63:56]};
            default:    w_field = '0;
        endcase
    end

    assign o_out_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        priority if (i_ctl.step) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
        if (i_ctl.step) begin
            r_index <= i_ctl.index;
            r_value <= w_field;
            r_last  <= i_ctl.last;
        end
    end

    assign o_valid = r_valid;
    assign o_index = r_index;
    assign o_value = r_value;
    assign o_last  = r_last;

endmodule

### src/cfsd_checker.sv
// ----------------------------------------------------------------------------
// Decoder port checker
// Port level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    `CFSD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

    `CFSD_ASSERT(a_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled request changed")

    `CFSD_ASSERT(a_index_range, i_clk, i_rst_n, o_m_axis_tvalid |-> o_m_axis_tdata[6:0] <= 7'd76, "signal index out of range")

    `CFSD_ASSERT(a_busy_mid_frame, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready, "new frame taken before the last signal")

endmodule

bind can_frame_signal_decoder_top cfsd_checker u_checker (.*);

### tb/can_frame_signal_decoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CAN frame signal decoder testbench
// Frames from a pending queue are offered on the input stream by a clocked
// driver. Each accepted frame is decoded here into the signal results it
// should produce. A clocked monitor compares every result on the output
// stream with the oldest outstanding one. Both sides idle at random outside
// the steady phase. The run walks through several base identifiers, including both extremes.
// ----------------------------------------------------------------------------
module can_frame_signal_decoder_top_tb;

    import cfsd_pkg::*;

    localparam int ClkHalf     = 2;
    localparam int ResetCycles = 12;
    localparam int IdlePercent = 37;
    localparam int HoldCycles  = 150;
    localparam int DrainCycles = 8;
    localparam int StallLimit  = 1000;
    localparam int ParamOffset = 'h22;

    typedef enum logic [2:0] {
        MSG_QUAD16,
        MSG_BYTES8,
        MSG_ANALOG,
        MSG_STATUS,
        MSG_TORQUE,
        MSG_DIAG,
        MSG_PARAM_RESP,
        MSG_UNUSED
    } t_msg_kind;

    typedef struct packed {
        logic                  last;
        logic [ValueWidth-1:0] value;
        logic [IndexWidth-1:0] index;
    } t_signal;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [BaseWidth-1:0]  cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [95:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [39:0]           m_tdata;
    logic                  m_tlast;

    logic [IdWidth+DataWidth-1:0] pending_frames [$];
    t_signal                      expected_signals [$];
    logic [BaseWidth-1:0]         base_id_model = BaseIdReset;
    logic                         sender_pause = 1'b0;
    logic                         steady = 1'b0;
    logic                         hold_go = 1'b0;
    int                           hold_left = 0;
    int                           fail_count = 0;
    int                           quiet_cycles = 0;
    int                           k;

    can_frame_signal_decoder_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    always #(ClkHalf) i_clk = ~i_clk;

    task automatic decode_frame(input logic [IdWidth-1:0] id, input logic [DataWidth-1:0] d);
        logic [ValueWidth-1:0] val [0:10];
        logic [IndexWidth-1:0] first;
        t_msg_kind             kind;
        t_signal               sig;
        int                    hit;
        int                    n;
        int                    off;
        int                    i;
        hit   = -1;
        n     = 0;
        first = '0;
        kind  = MSG_UNUSED;
        for (off = 0; off <= ParamOffset; off++) begin
            if (hit < 0 && (int'(base_id_model) + off) == int'(id)) begin
                hit = off;
            end
        end
        if (hit >= 0) begin
            kind = MSG_QUAD16;
            case (hit)
                'h00: first = 7'd0;
                'h01: first = 7'd4;
                'h02: first = 7'd8;
                'h03: begin
                    first = 7'd12;
                    kind  = MSG_ANALOG;
                end
                'h04: begin
                    first = 7'd17;
                    kind  = MSG_BYTES8;
                end
                'h05: first = 7'd25;
                'h06: first = 7'd29;
                'h07: first = 7'd33;
                'h08: first = 7'd37;
                'h09: first = 7'd41;
                'h0A: begin
                    first = 7'd45;
                    kind  = MSG_STATUS;
                end
                'h0B: first = 7'd56;
                'h0C: begin
                    first = 7'd60;
                    kind  = MSG_TORQUE;
                end
                'h0D: first = 7'd63;
                'h0E: first = 7'd67;
                'h0F: begin
                    first = 7'd71;
                    kind  = MSG_DIAG;
                end
                'h10: first = 7'd73;
                ParamOffset: kind = MSG_PARAM_RESP;
                default: kind = MSG_UNUSED;
            endcase
        end
        case (kind)
            MSG_QUAD16: begin
                for (i = 0; i < 4; i++) begin
                    val[i] = ValueWidth'(d[16*i +: 16]);
                end
                n = 4;
            end
            MSG_BYTES8: begin
                for (i = 0; i < 8; i++) begin
                    val[i] = ValueWidth'(d[8*i +: 8]);
                end
                n = 8;
            end
            MSG_ANALOG: begin
                val[0] = ValueWidth'(d[15:0]);
                val[1] = ValueWidth'(d[31:16]);
                val[2] = ValueWidth'(d[41:32]);
                val[3] = ValueWidth'(d[51:42]);
                val[4] = ValueWidth'(d[61:52]);
                n = 5;
            end
            MSG_STATUS: begin
                val[0]  = ValueWidth'(d[15:0]);
                val[1]  = ValueWidth'(d[23:16]);
                val[2]  = ValueWidth'(d[31:24]);
                val[3]  = ValueWidth'(d[32]);
                val[4]  = ValueWidth'(d[39:37]);
                val[5]  = ValueWidth'(d[47:40]);
                val[6]  = ValueWidth'(d[48]);
                val[7]  = ValueWidth'(d[55]);
                val[8]  = ValueWidth'(d[56]);
                val[9]  = ValueWidth'(d[57]);
                val[10] = ValueWidth'(d[58]);
                n = 11;
            end
            MSG_TORQUE: begin
                val[0] = ValueWidth'(d[15:0]);
                val[1] = ValueWidth'(d[31:16]);
                val[2] = d[63:32];
                n = 3;
            end
            MSG_DIAG: begin
                val[0] = {d[7:0], d[15:8], d[23:16], d[31:24]};
                val[1] = {d[39:32], d[47:40], d[55:48], d[63:56]};
                n = 2;
            end
            default: n = 0;
        endcase
        for (i = 0; i < n; i++) begin
            sig.index = first + IndexWidth'(i);
            sig.value = val[i];
            sig.last  = (i == n - 1);
            expected_signals.push_back(sig);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic queue_frame(input logic [IdWidth-1:0] id, input logic [DataWidth-1:0] d);
        pending_frames.push_back({d, id});
    endtask

    task automatic queue_random_frames(input int count);
        logic [IdWidth-1:0]   id;
        logic [DataWidth-1:0] d;
        int                   r;
        int                   pick;
        int                   i;
        for (i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 75) begin
                pick = $urandom_range(17);
                id   = IdWidth'(base_id_model) + IdWidth'((pick == 17) ? ParamOffset : pick);
            end else if (r < 85) begin
                id = IdWidth'($urandom);
            end else if (r < 95) begin
                pick = $urandom_range(1) ? $urandom_range('h11, 'h21) : $urandom_range('h23, 'h3F);
                id   = IdWidth'(base_id_model) + IdWidth'(pick);
            end else begin
                id = IdWidth'(base_id_model) - 1'b1;
            end
            r = $urandom_range(9);
            if (r == 0) begin
                d = '1;
            end else if (r == 1) begin
                d = '0;
            end else begin
                d = {$urandom, $urandom};
            end
            queue_frame(id, d);
        end
    endtask

    task automatic wait_idle();
        while (pending_frames.size() != 0 || s_tvalid || expected_signals.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_base_id(input logic [BaseWidth-1:0] value);
        @(posedge i_clk);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= value;
        base_id_model  = value;
        @(posedge i_clk);
        cfg_wr_en     <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_frame(s_tdata[IdWidth-1:0], s_tdata[IdWidth +: DataWidth]);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_frames.size() != 0 && !sender_pause
                        && (steady || $urandom_range(99) >= IdlePercent)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, pending_frames.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_go) begin
            hold_left <= HoldCycles;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        t_signal want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (hold_left == 0) && (steady || $urandom_range(99) >= IdlePercent);
            if (m_tvalid && m_tready) begin
                if (expected_signals.size() == 0) begin
                    report_mismatch("signal result with no frame outstanding",
                                    32'(m_tdata[6:0]), 32'd0);
                end else begin
                    want = expected_signals.pop_front();
                    if (m_tdata[6:0] !== want.index) begin
                        report_mismatch("signal_index", 32'(m_tdata[6:0]), 32'(want.index));
                    end
                    if (m_tdata[38:7] !== want.value) begin
                        report_mismatch("signal_value", m_tdata[38:7], want.value);
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch("last", 32'(m_tlast), 32'(want.last));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= StallLimit) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Each message at the reset base, a second status frame, then unmatched identifiers.
        for (k = 0; k <= 'h10; k++) begin
            case (k % 4)
                0: queue_frame(IdWidth'(BaseIdReset) + IdWidth'(k), '1);
                1: queue_frame(IdWidth'(BaseIdReset) + IdWidth'(k), '0);
                2: queue_frame(IdWidth'(BaseIdReset) + IdWidth'(k), 64'h0123_4567_89AB_CDEF);
                default: queue_frame(IdWidth'(BaseIdReset) + IdWidth'(k), {$urandom, $urandom});
            endcase
        end
        queue_frame(IdWidth'(BaseIdReset) + IdWidth'('h0A), 64'h5AA5_C33C_0FF0_96E9);
        queue_frame(IdWidth'(BaseIdReset) + IdWidth'(ParamOffset), '1);
        queue_frame(IdWidth'(BaseIdReset) - 1'b1, '1);
        queue_frame(IdWidth'(BaseIdReset) + IdWidth'('h11), '1);
        queue_frame('0, '1);
        queue_frame('1, '1);
        wait_idle();

        // Lowest base; the output side holds off while frames keep coming.
        write_base_id('0);
        queue_random_frames(30);
        @(posedge i_clk);
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        queue_random_frames(30);
        wait_idle();

        // Highest base, so matching sums run past the register width.
        write_base_id('1);
        queue_random_frames(50);
        while (pending_frames.size() > 25) begin
            @(posedge i_clk);
        end
        sender_pause <= 1'b1;
        @(posedge i_clk);
        while (s_tvalid || expected_signals.size() != 0) begin
            @(posedge i_clk);
        end
        sender_pause <= 1'b0;
        wait_idle();

        write_base_id(BaseWidth'($urandom_range(2047)));
        steady <= 1'b1;
        queue_random_frames(70);
        wait_idle();
        steady <= 1'b0;

        write_base_id(BaseWidth'($urandom_range(2047)));
        queue_random_frames(60);
        wait_idle();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/cfsd_pkg.sv
src/cfsd_seq.sv
src/cfsd_dp.sv
src/can_frame_signal_decoder_top.sv
src/cfsd_checker.sv
tb/can_frame_signal_decoder_top_tb.sv
